// ----- rtl/sd_card_init_sequencer_core_macros.svh -----
// Assertion macros shared by the SD init sequencer RTL.
`ifndef SD_CARD_INIT_SEQUENCER_CORE_MACROS_SVH
`define SD_CARD_INIT_SEQUENCER_CORE_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define SDI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sd init sequencer: assertion failed");

// Check that cons holds in the cycle after ante.
`define SDI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sd init sequencer: assertion failed");

`endif

// ----- rtl/sdinit_pkg.sv -----
// Types and constants of the SD card init sequencer.
`timescale 1ns / 1ps
package sdinit_pkg;

  localparam logic [7:0]  POLL_LIMIT   = 8'd200;

  localparam logic [5:0]  CMD_GO_IDLE  = 6'd0;
  localparam logic [5:0]  CMD_ALL_CID  = 6'd2;
  localparam logic [5:0]  CMD_SEND_RCA = 6'd3;
  localparam logic [5:0]  CMD_SWITCH_W = 6'd6;
  localparam logic [5:0]  CMD_SELECT   = 6'd7;
  localparam logic [5:0]  CMD_IF_COND  = 6'd8;
  localparam logic [5:0]  CMD_SEND_CSD = 6'd9;
  localparam logic [5:0]  CMD_BLOCKLEN = 6'd16;
  localparam logic [5:0]  CMD_OP_COND  = 6'd41;
  localparam logic [5:0]  CMD_APP      = 6'd55;

  localparam logic [31:0] IF_COND_ARG  = 32'h0000_01AA;
  localparam logic [11:0] IF_COND_ECHO = 12'h1AA;
  localparam logic [31:0] OP_COND_ARG  = 32'h00FF_8000;
  localparam logic [31:0] OP_COND_HCS  = 32'h4000_0000;
  localparam logic [31:0] BLOCK_LEN    = 32'd512;
  localparam logic [31:0] BUS_4BIT_ARG = 32'd2;

  localparam logic [2:0]  WAIT_PWR_MS  = 3'd2;
  localparam logic [2:0]  WAIT_POLL_MS = 3'd5;

  typedef enum logic [1:0] {
    ACT_CMD    = 2'd0,
    ACT_WAIT   = 2'd1,
    ACT_READY  = 2'd2,
    ACT_ABSENT = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    RESP_NONE  = 2'd0,
    RESP_SHORT = 2'd1,
    RESP_LONG  = 2'd2
  } resp_kind_t;

  typedef enum logic {
    REQ_START  = 1'b0,
    REQ_FINISH = 1'b1
  } req_type_t;

  typedef enum logic [13:0] {
    PH_IDLE  = 14'b00000000000001,
    PH_PWR   = 14'b00000000000010,
    PH_CMD0  = 14'b00000000000100,
    PH_CMD8  = 14'b00000000001000,
    PH_P55   = 14'b00000000010000,
    PH_P41   = 14'b00000000100000,
    PH_PWAIT = 14'b00000001000000,
    PH_CMD2  = 14'b00000010000000,
    PH_CMD3  = 14'b00000100000000,
    PH_CMD9  = 14'b00001000000000,
    PH_CMD7  = 14'b00010000000000,
    PH_CMD16 = 14'b00100000000000,
    PH_B55   = 14'b01000000000000,
    PH_B6    = 14'b10000000000000
  } phase_t;

  typedef struct packed {
    logic [6:0]  pad;
    logic [31:0] resp_word4;
    logic [31:0] resp_word3;
    logic [31:0] resp_word2;
    logic [31:0] resp_word1;
    logic        cmd_ok;
  } in_data_t;

  typedef struct packed {
    logic        pad;
    logic        wide_bus;
    logic        block_addressed;
    logic [15:0] card_address;
    logic [32:0] sector_count;
    logic [2:0]  wait_ms;
    logic        crc_skip;
    logic [1:0]  resp_kind;
    logic [31:0] cmd_arg;
    logic [5:0]  cmd_index;
  } out_data_t;

endpackage

// ----- rtl/sd_card_init_sequencer_core.sv -----
// SD card init sequencer: one request in, at most one wait/command/status out.
//
//  channel | dir | handshake          | payload
//  in_     | in  | tvalid / tready    | tdata: finish data, tuser: request type
//  out_    | out | tvalid / tready    | tdata: command and card info, tuser: action
//  cfg_    | in  | valid / ready      | data: force_one_bit_bus
//
// One request per cycle while the output is not stalled: a request is held in the
// input register and its result is registered in the output register as it leaves.
// The input register advances whenever the output register is empty or taken.
// rst_n is synchronous, active low, and returns the sequence to idle.
// An output stall holds the input register, and in_tready drops while it is full.
`timescale 1ns / 1ps
`include "sd_card_init_sequencer_core_macros.svh"
module sd_card_init_sequencer_core #(
  parameter logic [7:0] POLL_LIMIT = sdinit_pkg::POLL_LIMIT
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [0] cmd_ok, [32:1] resp_word1, [64:33] resp_word2, [96:65] resp_word3,
  // [128:97] resp_word4, [135:129] zero
  input  logic [135:0] in_tdata,
  // [0] req_type
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [5:0] cmd_index, [37:6] cmd_arg, [39:38] resp_kind, [40] crc_skip,
  // [43:41] wait_ms, [76:44] sector_count, [92:77] card_address,
  // [93] block_addressed, [94] wide_bus, [95] zero
  output logic [95:0]  out_tdata,
  // [1:0] action
  output logic [1:0]   out_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_data
);

  logic                  s1_valid_r;
  sdinit_pkg::req_type_t s1_req_r;
  sdinit_pkg::in_data_t  s1_data_r;
  logic                  s1_fire;

  logic                  force_one_bit_r;

  sdinit_pkg::phase_t    phase_r,   phase_nxt;
  logic                  is_v2_r,   is_v2_nxt;
  logic [7:0]            tries_r,   tries_nxt;
  logic                  hc_r,      hc_nxt;
  logic [15:0]           rca_r,     rca_nxt;
  logic [32:0]           cap_r,     cap_nxt;
  logic                  wide_r,    wide_nxt;

  logic                  out_valid_r;
  sdinit_pkg::out_data_t out_data_r;
  sdinit_pkg::action_t   out_action_r;

  logic                  res_valid;
  sdinit_pkg::out_data_t res_data;
  sdinit_pkg::action_t   res_action;
  logic                  go_absent;
  logic                  go_ready;
  logic                  go_bus;

  logic [21:0]           hc_csize;
  logic [32:0]           hc_sectors;
  logic [11:0]           sc_csize;
  logic [12:0]           sc_count;
  logic [4:0]            sc_shift;
  logic [36:0]           sc_bytes;
  logic [32:0]           sc_sectors;
  logic [32:0]           csd_sectors;

  assign s1_fire   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_action_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_req_r  <= sdinit_pkg::req_type_t'(in_tuser[0]);
      s1_data_r <= sdinit_pkg::in_data_t'(in_tdata);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      force_one_bit_r <= 1'b0;
    end else if (cfg_valid) begin
      force_one_bit_r <= cfg_data[0];
    end
  end

  always_comb begin
    hc_csize    = {s1_data_r.resp_word2[5:0], s1_data_r.resp_word3[31:16]};
    hc_sectors  = {({1'b0, hc_csize} + 23'd1), 10'b0};
    sc_csize    = {s1_data_r.resp_word2[9:8], s1_data_r.resp_word2[7:0],
                   s1_data_r.resp_word3[31:30]};
    sc_count    = {1'b0, sc_csize} + 13'd1;
    sc_shift    = {2'b0, s1_data_r.resp_word3[17:15]} + 5'd2
                  + {1'b0, s1_data_r.resp_word2[19:16]};
    sc_bytes    = {24'b0, sc_count} << sc_shift;
    sc_sectors  = {5'b0, sc_bytes[36:9]};
    csd_sectors = hc_r ? hc_sectors : sc_sectors;
  end

  always_comb begin
    phase_nxt  = phase_r;
    is_v2_nxt  = is_v2_r;
    tries_nxt  = tries_r;
    hc_nxt     = hc_r;
    rca_nxt    = rca_r;
    cap_nxt    = cap_r;
    wide_nxt   = wide_r;
    res_valid  = 1'b0;
    res_data   = '0;
    res_action = sdinit_pkg::ACT_CMD;
    go_absent  = 1'b0;
    go_ready   = 1'b0;
    go_bus     = 1'b0;

    if (s1_req_r == sdinit_pkg::REQ_START) begin
      is_v2_nxt        = 1'b0;
      tries_nxt        = '0;
      hc_nxt           = 1'b0;
      rca_nxt          = '0;
      cap_nxt          = '0;
      wide_nxt         = 1'b0;
      res_valid        = 1'b1;
      res_action       = sdinit_pkg::ACT_WAIT;
      res_data.wait_ms = sdinit_pkg::WAIT_PWR_MS;
      phase_nxt        = sdinit_pkg::PH_PWR;
    end else begin
      res_valid = 1'b1;
      unique case (phase_r)
        sdinit_pkg::PH_PWR: begin
          res_data.cmd_index = sdinit_pkg::CMD_GO_IDLE;
          res_data.resp_kind = sdinit_pkg::RESP_NONE;
          phase_nxt          = sdinit_pkg::PH_CMD0;
        end
        sdinit_pkg::PH_CMD0: begin
          res_data.cmd_index = sdinit_pkg::CMD_IF_COND;
          res_data.cmd_arg   = sdinit_pkg::IF_COND_ARG;
          res_data.resp_kind = sdinit_pkg::RESP_SHORT;
          phase_nxt          = sdinit_pkg::PH_CMD8;
        end
        sdinit_pkg::PH_CMD8: begin
          is_v2_nxt          = s1_data_r.cmd_ok &&
                               (s1_data_r.resp_word1[11:0] == sdinit_pkg::IF_COND_ECHO);
          tries_nxt          = '0;
          res_data.cmd_index = sdinit_pkg::CMD_APP;
          res_data.resp_kind = sdinit_pkg::RESP_SHORT;
          phase_nxt          = sdinit_pkg::PH_P55;
        end
        sdinit_pkg::PH_P55: begin
          if (!s1_data_r.cmd_ok) begin
            go_absent = 1'b1;
          end else begin
            res_data.cmd_index = sdinit_pkg::CMD_OP_COND;
            res_data.cmd_arg   = sdinit_pkg::OP_COND_ARG |
                                 (is_v2_r ? sdinit_pkg::OP_COND_HCS : 32'd0);
            res_data.resp_kind = sdinit_pkg::RESP_SHORT;
            res_data.crc_skip  = 1'b1;
            phase_nxt          = sdinit_pkg::PH_P41;
          end
        end
        sdinit_pkg::PH_P41: begin
          if (!s1_data_r.cmd_ok) begin
            go_absent = 1'b1;
          end else if (s1_data_r.resp_word1[31]) begin
            hc_nxt             = s1_data_r.resp_word1[30];
            res_data.cmd_index = sdinit_pkg::CMD_ALL_CID;
            res_data.resp_kind = sdinit_pkg::RESP_LONG;
            phase_nxt          = sdinit_pkg::PH_CMD2;
          end else begin
            tries_nxt        = tries_r + 8'd1;
            res_action       = sdinit_pkg::ACT_WAIT;
            res_data.wait_ms = sdinit_pkg::WAIT_POLL_MS;
            phase_nxt        = sdinit_pkg::PH_PWAIT;
          end
        end
        sdinit_pkg::PH_PWAIT: begin
          if (tries_r >= POLL_LIMIT) begin
            go_absent = 1'b1;
          end else begin
            res_data.cmd_index = sdinit_pkg::CMD_APP;
            res_data.resp_kind = sdinit_pkg::RESP_SHORT;
            phase_nxt          = sdinit_pkg::PH_P55;
          end
        end
        sdinit_pkg::PH_CMD2: begin
          if (!s1_data_r.cmd_ok) begin
            go_absent = 1'b1;
          end else begin
            res_data.cmd_index = sdinit_pkg::CMD_SEND_RCA;
            res_data.resp_kind = sdinit_pkg::RESP_SHORT;
            phase_nxt          = sdinit_pkg::PH_CMD3;
          end
        end
        sdinit_pkg::PH_CMD3: begin
          if (!s1_data_r.cmd_ok) begin
            go_absent = 1'b1;
          end else begin
            rca_nxt            = s1_data_r.resp_word1[31:16];
            res_data.cmd_index = sdinit_pkg::CMD_SEND_CSD;
            res_data.cmd_arg   = {s1_data_r.resp_word1[31:16], 16'b0};
            res_data.resp_kind = sdinit_pkg::RESP_LONG;
            phase_nxt          = sdinit_pkg::PH_CMD9;
          end
        end
        sdinit_pkg::PH_CMD9: begin
          if (!s1_data_r.cmd_ok || csd_sectors == 33'd0) begin
            go_absent = 1'b1;
          end else begin
            cap_nxt            = csd_sectors;
            res_data.cmd_index = sdinit_pkg::CMD_SELECT;
            res_data.cmd_arg   = {rca_r, 16'b0};
            res_data.resp_kind = sdinit_pkg::RESP_SHORT;
            phase_nxt          = sdinit_pkg::PH_CMD7;
          end
        end
        sdinit_pkg::PH_CMD7: begin
          if (!s1_data_r.cmd_ok) begin
            go_absent = 1'b1;
          end else if (!hc_r) begin
            res_data.cmd_index = sdinit_pkg::CMD_BLOCKLEN;
            res_data.cmd_arg   = sdinit_pkg::BLOCK_LEN;
            res_data.resp_kind = sdinit_pkg::RESP_SHORT;
            phase_nxt          = sdinit_pkg::PH_CMD16;
          end else begin
            go_bus = 1'b1;
          end
        end
        sdinit_pkg::PH_CMD16: begin
          if (!s1_data_r.cmd_ok) begin
            go_absent = 1'b1;
          end else begin
            go_bus = 1'b1;
          end
        end
        sdinit_pkg::PH_B55: begin
          if (!s1_data_r.cmd_ok) begin
            go_ready = 1'b1;
          end else begin
            res_data.cmd_index = sdinit_pkg::CMD_SWITCH_W;
            res_data.cmd_arg   = sdinit_pkg::BUS_4BIT_ARG;
            res_data.resp_kind = sdinit_pkg::RESP_SHORT;
            phase_nxt          = sdinit_pkg::PH_B6;
          end
        end
        sdinit_pkg::PH_B6: begin
          wide_nxt = s1_data_r.cmd_ok;
          go_ready = 1'b1;
        end
        default: begin
          res_valid = 1'b0;
          phase_nxt = sdinit_pkg::PH_IDLE;
        end
      endcase

      if (go_bus) begin
        wide_nxt = 1'b0;
        if (force_one_bit_r) begin
          go_ready = 1'b1;
        end else begin
          res_data.cmd_index = sdinit_pkg::CMD_APP;
          res_data.cmd_arg   = {rca_r, 16'b0};
          res_data.resp_kind = sdinit_pkg::RESP_SHORT;
          phase_nxt          = sdinit_pkg::PH_B55;
        end
      end

      if (go_absent) begin
        is_v2_nxt  = 1'b0;
        tries_nxt  = '0;
        hc_nxt     = 1'b0;
        rca_nxt    = '0;
        cap_nxt    = '0;
        wide_nxt   = 1'b0;
        res_data   = '0;
        res_action = sdinit_pkg::ACT_ABSENT;
        phase_nxt  = sdinit_pkg::PH_IDLE;
      end else if (go_ready) begin
        res_data                 = '0;
        res_data.sector_count    = cap_nxt;
        res_data.card_address    = rca_nxt;
        res_data.block_addressed = hc_nxt;
        res_data.wide_bus        = wide_nxt;
        res_action               = sdinit_pkg::ACT_READY;
        phase_nxt                = sdinit_pkg::PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= sdinit_pkg::PH_IDLE;
      is_v2_r <= 1'b0;
      tries_r <= '0;
      hc_r    <= 1'b0;
      rca_r   <= '0;
      cap_r   <= '0;
      wide_r  <= 1'b0;
    end else if (s1_fire) begin
      phase_r <= phase_nxt;
      is_v2_r <= is_v2_nxt;
      tries_r <= tries_nxt;
      hc_r    <= hc_nxt;
      rca_r   <= rca_nxt;
      cap_r   <= cap_nxt;
      wide_r  <= wide_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= res_valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && res_valid) begin
      out_data_r   <= res_data;
      out_action_r <= res_action;
    end
  end

  `SDI_ASSERT_NOW(a_phase_onehot, clk, rst_n, 1'b1, $onehot(phase_r))
  `SDI_ASSERT_NOW(a_tries_bound, clk, rst_n, 1'b1, tries_r <= POLL_LIMIT)
  `SDI_ASSERT_NOW(a_ready_nonzero, clk, rst_n, out_valid_r && out_action_r == sdinit_pkg::ACT_READY, out_data_r.sector_count != 33'd0)
  `SDI_ASSERT_NOW(a_cmd_fields_zero, clk, rst_n, out_valid_r && out_action_r != sdinit_pkg::ACT_CMD, out_data_r.cmd_index == 6'd0 && out_data_r.cmd_arg == 32'd0)
  `SDI_ASSERT_NEXT(a_start_wait, clk, rst_n, s1_fire && s1_req_r == sdinit_pkg::REQ_START, phase_r == sdinit_pkg::PH_PWR && out_valid_r && out_action_r == sdinit_pkg::ACT_WAIT)

endmodule
